### sv/vat_pkg.sv
// ============================================================================
// vat_pkg: shared types, constants and arithmetic for the vector arctangent
// Fixed-point formats, polynomial coefficients and the rounding multiply.
// ============================================================================
package vat_pkg;

    localparam int FRAC_BITS  = 16;                 // output/input fraction bits
    localparam int LANES      = 8;
    localparam int IFB        = 30;                 // internal fraction bits
    localparam int IW         = FRAC_BITS + 4;      // argument width, Q4.F
    localparam int OW         = FRAC_BITS + 1;      // angle width, Q1.F
    localparam int DW         = IW + 1;             // divider operand width
    localparam int QB         = IFB + 1;            // quotient bits
    localparam int NW         = DW + IFB;           // dividend width
    localparam int SH         = IFB - FRAC_BITS;    // Q.30 -> Q.F shift
    localparam int VW         = 36;                 // internal signed width
    localparam int TW         = IW + SH;            // argument at Q.30
    localparam int LANE_DEPTH = QB + 1 + 7;         // register stages in a lane

    localparam longint unsigned DEC_SCALE = 64'd10000000000;

    typedef logic signed [VW-1:0] val_t;

    // decimal constant scaled by 1e10 -> Q.30, round to nearest
    function automatic longint unsigned q30(input longint unsigned d);
        return ((d << IFB) + DEC_SCALE / 2) / DEC_SCALE;
    endfunction

    localparam val_t C_PIO4  = val_t'(q30(64'd7853981634));
    localparam val_t C_TANP8 = val_t'(q30(64'd4142135624));
    localparam val_t C_P0    = val_t'(q30(64'd805374450));
    localparam val_t C_P1    = val_t'(q30(64'd1387768560));
    localparam val_t C_P2    = val_t'(q30(64'd1997771065));
    localparam val_t C_P3    = val_t'(q30(64'd3333294915));

    // upper bound on any angle code: pi/2 at Q.F plus margin
    localparam longint unsigned ANGLE_BOUND =
        ((64'd1570796327 << FRAC_BITS) / 64'd1000000000) + 64'd4;

    // sign-magnitude multiply, round half away from zero at Q.30
    function automatic val_t fx_mul(input val_t a, input val_t b);
        logic [VW-1:0]   ma;
        logic [VW-1:0]   mb;
        logic [2*VW-1:0] pr;
        logic [VW-1:0]   m;
        ma = a[VW-1] ? VW'(-a) : VW'(a);
        mb = b[VW-1] ? VW'(-b) : VW'(b);
        pr = ({{VW{1'b0}}, ma} * {{VW{1'b0}}, mb}) + ((2*VW)'(1) << (IFB - 1));
        m  = pr[IFB +: VW];
        return (a[VW-1] ^ b[VW-1]) ? val_t'(-m) : val_t'(m);
    endfunction

endpackage

### sv/vector_arctangent.sv
// ============================================================================
// vector_arctangent: eight-lane fixed-point arctangent
// Eight independent lanes; the output stage gathers their angles into one item.
// ============================================================================
// Usage:
//   Input channel arg_valid/arg_ready carries eight unsigned Q4.16 arguments
//   (arg0..arg7). Output channel angle_valid/angle_ready carries eight
//   unsigned Q1.16 angles in radians (angle0..angle7), lane for lane.
//   Stages: 32 divider stages, 7 polynomial stages and 1 output register
//     between input accept and angle_valid.
//   Throughput: one item per cycle; the fixed pipeline accepts a new item
//     every clock while the output register is free or being taken.
//   Stall: while angle_valid is high and angle_ready low, the whole pipeline
//     holds and arg_ready is low; nothing is lost or repeated.
//   Reset: rst_n clears all valid flags; the pipeline is empty and ready
//     right after reset. Data registers are not reset.
//   Arguments above tan(pi/8) go through z=(t-1)/(t+1) in a pipelined
//   divider; pi/4 is added back for those lanes before rounding.
// ============================================================================
module vector_arctangent
    import vat_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          arg_valid,
    output logic          arg_ready,
    input  logic [IW-1:0] arg0,
    input  logic [IW-1:0] arg1,
    input  logic [IW-1:0] arg2,
    input  logic [IW-1:0] arg3,
    input  logic [IW-1:0] arg4,
    input  logic [IW-1:0] arg5,
    input  logic [IW-1:0] arg6,
    input  logic [IW-1:0] arg7,
    output logic          angle_valid,
    input  logic          angle_ready,
    output logic [OW-1:0] angle0,
    output logic [OW-1:0] angle1,
    output logic [OW-1:0] angle2,
    output logic [OW-1:0] angle3,
    output logic [OW-1:0] angle4,
    output logic [OW-1:0] angle5,
    output logic [OW-1:0] angle6,
    output logic [OW-1:0] angle7
);

    logic                  en;
    logic [LANE_DEPTH-1:0] vld_reg;
    logic                  out_vld_reg;
    logic [IW-1:0]         lane_arg   [0:LANES-1];
    logic [OW-1:0]         lane_angle [0:LANES-1];
    logic [OW-1:0]         angle_reg  [0:LANES-1];

    // pipeline advances unless a finished item is waiting on the receiver
    assign en        = !out_vld_reg || angle_ready;
    assign arg_ready = en;

    assign lane_arg[0] = arg0;
    assign lane_arg[1] = arg1;
    assign lane_arg[2] = arg2;
    assign lane_arg[3] = arg3;
    assign lane_arg[4] = arg4;
    assign lane_arg[5] = arg5;
    assign lane_arg[6] = arg6;
    assign lane_arg[7] = arg7;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        vat_lane u_lane (
            .clk   (clk),
            .en    (en),
            .arg   (lane_arg[i]),
            .angle (lane_angle[i])
        );
    end

    // valid tracking, aligned with lane stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[LANE_DEPTH-2:0], arg_valid};
            out_vld_reg <= vld_reg[LANE_DEPTH-1];
        end
    end

    // merge: all lane angles land in one output item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                angle_reg[i] <= lane_angle[i];
            end
        end
    end

    assign angle_valid = out_vld_reg;
    assign angle0      = angle_reg[0];
    assign angle1      = angle_reg[1];
    assign angle2      = angle_reg[2];
    assign angle3      = angle_reg[3];
    assign angle4      = angle_reg[4];
    assign angle5      = angle_reg[5];
    assign angle6      = angle_reg[6];
    assign angle7      = angle_reg[7];

`ifndef SYNTHESIS
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !arg_ready |=> $stable(vld_reg))
        else $error("pipeline valids moved during stall");

    a_lane0_bound: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (64'(angle0) <= ANGLE_BOUND))
        else $error("lane 0 angle above pi/2");

    a_lane7_bound: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (64'(angle7) <= ANGLE_BOUND))
        else $error("lane 7 angle above pi/2");
`endif

endmodule

### sv/vat_div.sv
// ============================================================================
// vat_div: pipelined restoring divider
// Rounded quotient of (num << 30) / den, one quotient bit per stage.
// ============================================================================
module vat_div
    import vat_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] q
);

    logic [NW-1:0] dvd;
    logic [DW-1:0] rem_reg [0:QB-1];
    logic [DW-1:0] den_reg [0:QB-1];
    logic [QB-1:0] nlo_reg [0:QB-1];
    logic [QB-1:0] q_reg   [0:QB];
    logic [DW:0]   trial   [0:QB-1];
    logic          ge      [0:QB-1];

    // half divisor added for round to nearest
    assign dvd = {num, {IFB{1'b0}}} + NW'(den >> 1);

    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            trial[k] = {rem_reg[k], nlo_reg[k][QB-1-k]};
            ge[k]    = trial[k] >= {1'b0, den_reg[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(dvd[NW-1:QB]);
            den_reg[0] <= den;
            nlo_reg[0] <= dvd[QB-1:0];
            q_reg[0]   <= '0;
            for (int k = 0; k < QB; k++)
            begin
                q_reg[k+1] <= {q_reg[k][QB-2:0], ge[k]};
                if (k < QB - 1)
                begin
                    rem_reg[k+1] <= ge[k] ? DW'(trial[k] - {1'b0, den_reg[k]})
                                          : DW'(trial[k]);
                    den_reg[k+1] <= den_reg[k];
                    nlo_reg[k+1] <= nlo_reg[k];
                end
            end
        end
    end

    assign q = q_reg[QB];

endmodule

### sv/vat_lane.sv
// ============================================================================
// vat_lane: one arctangent lane
// Range reduction, pipelined divide, degree-9 odd polynomial, pi/4 add-back.
// ============================================================================
module vat_lane
    import vat_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [IW-1:0] arg,
    output logic [OW-1:0] angle
);

    localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    logic [TW-1:0] t30;
    val_t          t30_v;
    logic          red_in;
    logic          neg_in;
    logic [DW-1:0] den;
    logic [DW-1:0] num;
    logic [QB-1:0] q;

    // side data riding along with the divider
    logic          sred_reg [0:QB];
    logic          sneg_reg [0:QB];
    val_t          st30_reg [0:QB];

    val_t          z_next;
    val_t          z_reg    [0:5];
    logic          red_reg  [0:6];
    val_t          z2_reg   [1:4];
    val_t          p_reg    [2:6];

    val_t          sum;
    val_t          clamped;
    val_t          rnd;

    assign t30    = {arg, {SH{1'b0}}};
    assign t30_v  = val_t'(t30);
    assign red_in = t30_v > C_TANP8;
    assign den    = DW'(arg) + ONE;
    assign neg_in = DW'(arg) < ONE;
    assign num    = neg_in ? ONE - DW'(arg) : DW'(arg) - ONE;

    vat_div u_div (
        .clk (clk),
        .en  (en),
        .num (num),
        .den (den),
        .q   (q)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sred_reg[0] <= red_in;
            sneg_reg[0] <= neg_in;
            st30_reg[0] <= t30_v;
            for (int k = 1; k <= QB; k++)
            begin
                sred_reg[k] <= sred_reg[k-1];
                sneg_reg[k] <= sneg_reg[k-1];
                st30_reg[k] <= st30_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (!sred_reg[QB])
            z_next = st30_reg[QB];
        else if (sneg_reg[QB])
            z_next = -val_t'(q);
        else
            z_next = val_t'(q);
    end

    // polynomial chain, at most one multiply per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]   <= z_next;
            red_reg[0] <= sred_reg[QB];
            for (int k = 1; k <= 5; k++)
            begin
                z_reg[k] <= z_reg[k-1];
            end
            for (int k = 1; k <= 6; k++)
            begin
                red_reg[k] <= red_reg[k-1];
            end
            z2_reg[1] <= fx_mul(z_reg[0], z_reg[0]);
            for (int k = 2; k <= 4; k++)
            begin
                z2_reg[k] <= z2_reg[k-1];
            end
            p_reg[2] <= fx_mul(C_P0, z2_reg[1]) - C_P1;
            p_reg[3] <= fx_mul(p_reg[2], z2_reg[2]) + C_P2;
            p_reg[4] <= fx_mul(p_reg[3], z2_reg[3]) - C_P3;
            p_reg[5] <= fx_mul(p_reg[4], z2_reg[4]);
            p_reg[6] <= fx_mul(p_reg[5], z_reg[5]) + z_reg[5];
        end
    end

    always_comb
    begin
        sum     = p_reg[6] + (red_reg[6] ? C_PIO4 : val_t'(0));
        clamped = sum[VW-1] ? val_t'(0) : sum;
        rnd     = (clamped + (val_t'(1) <<< (SH - 1))) >>> SH;
        if (rnd > val_t'({OW{1'b1}}))
            angle = {OW{1'b1}};
        else
            angle = rnd[OW-1:0];
    end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the eight-lane vector arctangent
// Sends argument vectors with random gaps, stalls the angle side, and compares
// every angle with an in-bench fixed-point predictor in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    import vat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [LANES-1:0][IW-1:0] arg_vec_t;
    typedef logic [LANES-1:0][OW-1:0] angle_vec_t;

    // Q.30 constants, decimal scaled by 1e10, round to nearest
    localparam longint unsigned DSC = 64'd10000000000;
    localparam longint K_PIO4  = ((64'd7853981634 << 30) + DSC / 2) / DSC;
    localparam longint K_TANP8 = ((64'd4142135624 << 30) + DSC / 2) / DSC;
    localparam longint K_P0    = ((64'd805374450 << 30) + DSC / 2) / DSC;
    localparam longint K_P1    = ((64'd1387768560 << 30) + DSC / 2) / DSC;
    localparam longint K_P2    = ((64'd1997771065 << 30) + DSC / 2) / DSC;
    localparam longint K_P3    = ((64'd3333294915 << 30) + DSC / 2) / DSC;
    localparam longint unsigned ANGLE_MAX = (64'd1 << OW) - 1;
    localparam int DRAIN_CYCLES = 60;   // longer than the pipeline depth

    logic          clk;
    logic          rst_n;
    logic          arg_valid;
    logic          arg_ready;
    logic [IW-1:0] arg0, arg1, arg2, arg3, arg4, arg5, arg6, arg7;
    logic          angle_valid;
    logic          angle_ready;
    logic [OW-1:0] angle0, angle1, angle2, angle3, angle4, angle5, angle6, angle7;

    angle_vec_t expected_angles[$];
    int         error_count;
    bit         stall_enable;     // angle side may drop ready
    bit         gap_enable;       // argument side may leave gaps

    vector_arctangent uut (
        .clk(clk), .rst_n(rst_n),
        .arg_valid(arg_valid), .arg_ready(arg_ready),
        .arg0(arg0), .arg1(arg1), .arg2(arg2), .arg3(arg3),
        .arg4(arg4), .arg5(arg5), .arg6(arg6), .arg7(arg7),
        .angle_valid(angle_valid), .angle_ready(angle_ready),
        .angle0(angle0), .angle1(angle1), .angle2(angle2), .angle3(angle3),
        .angle4(angle4), .angle5(angle5), .angle6(angle6), .angle7(angle7)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Signed Q.30 multiply on magnitudes, round half away from zero.
    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        m  = (ma * mb + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // atan of one unsigned Q4.F argument, as Q1.F radians.
    function automatic logic [OW-1:0] lane_angle(input logic [IW-1:0] t);
        longint unsigned one;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        longint unsigned r;
        longint          t30;
        longint          z;
        longint          z2;
        longint          p;
        bit              reduce;
        bit              below_one;
        one    = 64'd1 << FRAC_BITS;
        t30    = longint'(t) << (30 - FRAC_BITS);
        reduce = t30 > K_TANP8;      // exact tan(pi/8) stays unreduced
        if (reduce)
        begin
            den       = t + one;
            below_one = t < one;
            num       = below_one ? one - t : t - one;
            q         = ((num << 30) + den / 2) / den;
            z         = below_one ? -longint'(q) : longint'(q);
        end
        else
            z = t30;
        z2 = q30_mul(z, z);
        p  = q30_mul(K_P0, z2) - K_P1;
        p  = q30_mul(p, z2) + K_P2;
        p  = q30_mul(p, z2) - K_P3;
        p  = q30_mul(p, z2);
        p  = q30_mul(p, z) + z;
        if (reduce)
            p = p + K_PIO4;
        if (p < 0)
            p = 0;                   // negative sum clamps to zero
        r = (longint'(p) + (64'd1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
        if (r > ANGLE_MAX)
            r = ANGLE_MAX;
        return r[OW-1:0];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input int lane, input logic [OW-1:0] got,
                                   input logic [OW-1:0] want);
        $display("mismatch lane %0d: got %0h expected %0h at %0t", lane, got, want,
                 $realtime);
        error_count++;
    endtask

    // One item onto the argument channel. Valid stays high across back-to-back
    // items; it only drops when a gap is taken.
    task automatic send_vector(input arg_vec_t v);
        angle_vec_t want;
        int         gap;
        gap = gap_enable ? pick_gap() : 0;
        if (gap > 0)
        begin
            arg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        arg_valid <= 1'b1;
        arg0 <= v[0]; arg1 <= v[1]; arg2 <= v[2]; arg3 <= v[3];
        arg4 <= v[4]; arg5 <= v[5]; arg6 <= v[6]; arg7 <= v[7];
        for (int i = 0; i < LANES; i++)
            want[i] = lane_angle(v[i]);
        do
            @(posedge clk);
        while (!arg_ready);
        expected_angles.push_back(want);
    endtask

    task automatic finish_sending();
        arg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_empty();
        while (expected_angles.size() != 0)
            @(posedge clk);
    endtask

    // Random argument: often the busy region around 0..2, some near the
    // reduction threshold, the rest anywhere in the full Q4.16 range.
    function automatic logic [IW-1:0] random_arg();
        int          roll;
        logic [IW-1:0] th;
        th   = IW'(K_TANP8 >>> (30 - FRAC_BITS));
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return IW'($urandom_range(0, 2 << FRAC_BITS));
        else if (roll < 50)
            return th + IW'($urandom_range(0, 8)) - IW'(4);
        else
            return IW'($urandom);
    endfunction

    task automatic test_directed();
        arg_vec_t      v;
        logic [IW-1:0] th;
        logic [IW-1:0] one;
        th  = IW'(K_TANP8 >>> (30 - FRAC_BITS));
        one = IW'(1) << FRAC_BITS;
        v = '{default: '0};
        send_vector(v);
        v = '{default: '1};
        send_vector(v);
        // zero, max, one, threshold neighborhood, just under/over one
        v = '{th - IW'(1), th, th + IW'(1), one, one - IW'(1), one + IW'(1),
              IW'(0), {IW{1'b1}}};
        send_vector(v);
        v = '{IW'(1), IW'(2) << FRAC_BITS, IW'(3) << FRAC_BITS, IW'(1) << (IW - 1),
              IW'(5) << FRAC_BITS, IW'(32768), IW'(20000), IW'(100)};
        send_vector(v);
        for (int b = 0; b < IW; b++)
        begin
            for (int i = 0; i < LANES; i++)
                v[i] = IW'(1) << ((b + i) % IW);
            send_vector(v);
        end
    endtask

    task automatic test_random(input int count);
        arg_vec_t v;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < LANES; i++)
                v[i] = random_arg();
            send_vector(v);
        end
    endtask

    // Check every arriving angle vector against the oldest prediction.
    always @(posedge clk)
    begin
        angle_vec_t got;
        angle_vec_t want;
        if (rst_n && angle_valid && angle_ready)
        begin
            got = {angle7, angle6, angle5, angle4, angle3, angle2, angle1, angle0};
            if (expected_angles.size() == 0)
            begin
                $display("unexpected angle item at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = expected_angles.pop_front();
                for (int i = 0; i < LANES; i++)
                    if (got[i] !== want[i])
                        report_mismatch(i, got[i], want[i]);
            end
        end
    end

    // Angle side back-pressure.
    initial
    begin
        int hold;
        angle_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!stall_enable)
                angle_ready <= 1'b1;
            else
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    angle_ready <= 1'b0;
                    repeat (hold - 1) @(posedge clk);
                    @(posedge clk);
                end
                angle_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        error_count  = 0;
        stall_enable = 1'b0;
        gap_enable   = 1'b0;
        rst_n        = 1'b0;
        arg_valid    = 1'b0;
        {arg0, arg1, arg2, arg3, arg4, arg5, arg6, arg7} = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // full rate, no idling on either side
        test_random(80);
        // sender holds off until the pipeline has fully drained
        finish_sending();
        wait_for_empty();
        stall_enable = 1'b1;
        gap_enable   = 1'b1;
        test_random(300);
        gap_enable   = 1'b0;
        test_random(70);
        finish_sending();

        wait_for_empty();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
